[design/assert_macros.svh]
// Assertion macros shared by the RTL of the minimum corner sine block.
// Needs nothing else; the asserting files take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QMCSJ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QMCSJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QMCSJ_ASSERT(lbl, clk, rst_n, prop, msg)
`define QMCSJ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/qmcsj_pkg.sv]
// Package for the quad minimum corner sine block: widths, stage counts and types.
// Depends on nothing; every other file but the assertion macro header imports it.
`default_nettype none

package qmcsj_pkg;

    localparam int COORD_W    = 24;
    localparam int SIDE_W     = 25;
    localparam int PROD_W     = 2 * SIDE_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int LEN_W      = 50;
    localparam int HALF_W     = LEN_W / 2;
    localparam int PP_W       = 2 * HALF_W;
    localparam int WIDE_W     = 2 * LEN_W;
    localparam int QUO_W      = 31;
    localparam int ROOT_W     = 32;
    localparam int SINE_W     = 16;
    localparam int NUM_LANES  = 4;
    localparam int FRONT_STEPS = 5;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = 16;
    localparam int LANE_DEPTH = FRONT_STEPS + DIV_STEPS + SQRT_STEPS;

    localparam logic [SINE_W-1:0] SINE_ONE = 16'h8000;

    typedef logic [COORD_W-1:0]          coord_t;
    typedef logic [2:0][SIDE_W-1:0]      vec_t;
    typedef logic [LEN_W-1:0]            len_t;
    typedef logic [WIDE_W-1:0]           wide_t;
    typedef logic [QUO_W-1:0]            quo_t;
    typedef logic [SINE_W-1:0]           sine_t;

endpackage : qmcsj_pkg

`default_nettype wire

[design/qmcsj_quad_if.sv]
// Input channel interface: one quad of four 3D corners per transfer.
// Depends on qmcsj_pkg.
`default_nettype none

interface qmcsj_quad_if;
    import qmcsj_pkg::*;

    logic   valid;
    logic   ready;
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t corner_c_z;
    coord_t corner_d_x;
    coord_t corner_d_y;
    coord_t corner_d_z;

    modport source (
        output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
        output corner_b_z, corner_c_x, corner_c_y, corner_c_z, corner_d_x,
        output corner_d_y, corner_d_z,
        input  ready
    );
    modport sink (
        input  valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
        input  corner_b_z, corner_c_x, corner_c_y, corner_c_z, corner_d_x,
        input  corner_d_y, corner_d_z,
        output ready
    );

endinterface : qmcsj_quad_if

`default_nettype wire

[design/qmcsj_result_if.sv]
// Output channel interface: minimum corner sine and degenerate flag per transfer.
// Depends on qmcsj_pkg.
`default_nettype none

interface qmcsj_result_if;
    import qmcsj_pkg::*;

    logic  valid;
    logic  ready;
    sine_t min_corner_sine;
    logic  degenerate;

    modport source (output valid, min_corner_sine, degenerate, input ready);
    modport sink (input valid, min_corner_sine, degenerate, output ready);

endinterface : qmcsj_result_if

`default_nettype wire

[design/qmcsj_div.sv]
// Pipelined restoring divider: floor(2^30 * c / p) for c <= p, one quotient bit a stage.
// Depends on qmcsj_pkg.
`default_nettype none

module qmcsj_div (
    input  wire                      clk,
    input  wire                      en,
    input  wire qmcsj_pkg::wide_t    num,
    input  wire qmcsj_pkg::wide_t    den,
    output qmcsj_pkg::quo_t          quo
);
    import qmcsj_pkg::*;

    wide_t rem_reg [DIV_STEPS];
    wide_t den_reg [DIV_STEPS];
    quo_t  quo_reg [DIV_STEPS];
    wide_t rem_next [DIV_STEPS];
    quo_t  quo_next [DIV_STEPS];

    // The first step compares without a shift, as the numerator may equal the divisor.
    always_comb
    begin
        logic [WIDE_W:0] trial;
        logic            ge;
        trial = {1'b0, num};
        ge = (trial >= {1'b0, den});
        rem_next[0] = ge ? WIDE_W'(trial - {1'b0, den}) : num;
        quo_next[0] = {{(QUO_W-1){1'b0}}, ge};
    end

    genvar j;
    generate
        for (j = 1; j < DIV_STEPS; j++)
        begin : g_step
            logic [WIDE_W:0] shifted;
            logic            ge;
            assign shifted = {rem_reg[j-1], 1'b0};
            assign ge = (shifted >= {1'b0, den_reg[j-1]});
            assign rem_next[j] = ge ? WIDE_W'(shifted - {1'b0, den_reg[j-1]})
                                    : WIDE_W'(shifted);
            assign quo_next[j] = {quo_reg[j-1][QUO_W-2:0], ge};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
            den_reg[0] <= den;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                den_reg[i] <= den_reg[i-1];
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule : qmcsj_div

`default_nettype wire

[design/qmcsj_sqrt.sv]
// Pipelined integer square root of a 31-bit value, one result bit a stage.
// Depends on qmcsj_pkg.
`default_nettype none

module qmcsj_sqrt (
    input  wire                      clk,
    input  wire                      en,
    input  wire qmcsj_pkg::quo_t     rad,
    output qmcsj_pkg::sine_t         root
);
    import qmcsj_pkg::*;

    logic [ROOT_W-1:0] res_reg  [SQRT_STEPS];
    quo_t              rad_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] res_next [SQRT_STEPS];
    quo_t              rad_next [SQRT_STEPS];

    genvar i;
    generate
        for (i = 0; i < SQRT_STEPS; i++)
        begin : g_step
            localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - i));
            logic [ROOT_W-1:0] res_in;
            quo_t              rad_in;
            logic [ROOT_W-1:0] trial;
            logic              ge;
            if (i == 0)
            begin : g_first
                assign res_in = '0;
                assign rad_in = rad;
            end
            else
            begin : g_rest
                assign res_in = res_reg[i-1];
                assign rad_in = rad_reg[i-1];
            end
            assign trial = res_in + BIT;
            assign ge = ({1'b0, rad_in} >= trial);
            assign rad_next[i] = ge ? QUO_W'({1'b0, rad_in} - trial) : rad_in;
            assign res_next[i] = ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                res_reg[k] <= res_next[k];
                rad_reg[k] <= rad_next[k];
            end
        end
    end

    assign root = res_reg[SQRT_STEPS-1][SINE_W-1:0];

endmodule : qmcsj_sqrt

`default_nettype wire

[design/qmcsj_lane.sv]
// One corner lane: squared lengths and dot product, wide products, then divide and root.
// Depends on qmcsj_pkg, qmcsj_div and qmcsj_sqrt.
`default_nettype none

module qmcsj_lane (
    input  wire                      clk,
    input  wire                      en,
    input  wire qmcsj_pkg::vec_t     u,
    input  wire qmcsj_pkg::vec_t     v,
    output qmcsj_pkg::sine_t         sine
);
    import qmcsj_pkg::*;

    logic signed [PROD_W-1:0] uu_reg [3];
    logic signed [PROD_W-1:0] vv_reg [3];
    logic signed [PROD_W-1:0] uv_reg [3];
    len_t l1_reg, l2_reg, ad_reg;
    logic [PP_W-1:0] pp_reg [4];
    logic [PP_W-1:0] dp_reg [4];
    wide_t p_reg, dd_reg, c_reg, den_reg;

    logic signed [SUM_W-1:0] l1_sum, l2_sum, dot_sum;
    len_t ad_abs;

    always_comb
    begin
        l1_sum  = SUM_W'(uu_reg[0]) + SUM_W'(uu_reg[1]) + SUM_W'(uu_reg[2]);
        l2_sum  = SUM_W'(vv_reg[0]) + SUM_W'(vv_reg[1]) + SUM_W'(vv_reg[2]);
        dot_sum = SUM_W'(uv_reg[0]) + SUM_W'(uv_reg[1]) + SUM_W'(uv_reg[2]);
        ad_abs  = dot_sum[SUM_W-1] ? LEN_W'(-dot_sum) : LEN_W'(dot_sum);
    end

    // Each 50-bit length is split in two halves so that every multiplier is 25 by 25.
    function automatic wide_t join_pp(input logic [PP_W-1:0] p00, input logic [PP_W-1:0] p01,
                                      input logic [PP_W-1:0] p10, input logic [PP_W-1:0] p11);
        wide_t mid;
        mid = WIDE_W'(p01) + WIDE_W'(p10);
        return WIDE_W'(p00) + (mid << HALF_W) + (WIDE_W'(p11) << LEN_W);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                uu_reg[i] <= PROD_W'($signed(u[i]) * $signed(u[i]));
                vv_reg[i] <= PROD_W'($signed(v[i]) * $signed(v[i]));
                uv_reg[i] <= PROD_W'($signed(u[i]) * $signed(v[i]));
            end
            l1_reg <= LEN_W'(l1_sum);
            l2_reg <= LEN_W'(l2_sum);
            ad_reg <= ad_abs;
            pp_reg[0] <= l1_reg[HALF_W-1:0] * l2_reg[HALF_W-1:0];
            pp_reg[1] <= l1_reg[HALF_W-1:0] * l2_reg[LEN_W-1:HALF_W];
            pp_reg[2] <= l1_reg[LEN_W-1:HALF_W] * l2_reg[HALF_W-1:0];
            pp_reg[3] <= l1_reg[LEN_W-1:HALF_W] * l2_reg[LEN_W-1:HALF_W];
            dp_reg[0] <= ad_reg[HALF_W-1:0] * ad_reg[HALF_W-1:0];
            dp_reg[1] <= ad_reg[HALF_W-1:0] * ad_reg[LEN_W-1:HALF_W];
            dp_reg[2] <= ad_reg[LEN_W-1:HALF_W] * ad_reg[HALF_W-1:0];
            dp_reg[3] <= ad_reg[LEN_W-1:HALF_W] * ad_reg[LEN_W-1:HALF_W];
            p_reg  <= join_pp(pp_reg[0], pp_reg[1], pp_reg[2], pp_reg[3]);
            dd_reg <= join_pp(dp_reg[0], dp_reg[1], dp_reg[2], dp_reg[3]);
            // A negative radicand is clamped to zero.
            c_reg   <= (p_reg >= dd_reg) ? (p_reg - dd_reg) : '0;
            den_reg <= p_reg;
        end
    end

    quo_t quo;

    qmcsj_div u_div (
        .clk (clk),
        .en  (en),
        .num (c_reg),
        .den (den_reg),
        .quo (quo)
    );

    qmcsj_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (quo),
        .root (sine)
    );

endmodule : qmcsj_lane

`default_nettype wire

[design/qmcsj_merge.sv]
// Merging stage: minimum of the four lane sines, forced to zero for a degenerate quad.
// Depends on qmcsj_pkg.
`default_nettype none

module qmcsj_merge (
    input  wire qmcsj_pkg::sine_t    lane_sine [qmcsj_pkg::NUM_LANES],
    input  wire                      degen,
    output qmcsj_pkg::sine_t         merged
);
    import qmcsj_pkg::*;

    sine_t min01, min23, min_all;

    always_comb
    begin
        min01   = (lane_sine[1] < lane_sine[0]) ? lane_sine[1] : lane_sine[0];
        min23   = (lane_sine[3] < lane_sine[2]) ? lane_sine[3] : lane_sine[2];
        min_all = (min23 < min01) ? min23 : min01;
        merged  = degen ? '0 : min_all;
    end

endmodule : qmcsj_merge

`default_nettype wire

[design/quad_min_corner_scaled_jacobian.sv]
// Minimum corner sine of a 3D quadrilateral, unsigned Q1.15, one quad per cycle unless stalled.
// Throughput: one quad per cycle; the whole pipeline advances together and
// halts only while a finished result waits at the output register.
// Reset (asynchronous, active low) clears the valid pipeline and the output valid.
`default_nettype none

module quad_min_corner_scaled_jacobian (
    input  wire              clk,
    input  wire              rst_n,
    qmcsj_quad_if.sink       quad,
    qmcsj_result_if.source   result
);
    import qmcsj_pkg::*;

    // Pipeline structure:
    //   stage 0      edge vectors AB, BC, CD, DA and the degenerate check are
    //                registered, and each lane is given its corner's pair of edges
    //                (the edge to the next corner, and the reversed edge from the
    //                previous one).
    //   stages 1-52  four identical lanes, one per corner, compute the squared
    //                sine as an exact fraction, divide it out to 31 bits and take
    //                the integer square root, one bit a stage.
    //   stage 53     the merging stage takes the minimum over the lanes and
    //                registers the result for the output transfer.
    // Each stage holds its contents while the output is stalled, so the output
    // register doubles as the holding stage and nothing is lost or repeated.

    logic advance;
    assign advance = !result.valid || result.ready;
    assign quad.ready = advance;

    coord_t pt [4][3];
    assign pt[0][0] = quad.corner_a_x;
    assign pt[0][1] = quad.corner_a_y;
    assign pt[0][2] = quad.corner_a_z;
    assign pt[1][0] = quad.corner_b_x;
    assign pt[1][1] = quad.corner_b_y;
    assign pt[1][2] = quad.corner_b_z;
    assign pt[2][0] = quad.corner_c_x;
    assign pt[2][1] = quad.corner_c_y;
    assign pt[2][2] = quad.corner_c_z;
    assign pt[3][0] = quad.corner_d_x;
    assign pt[3][1] = quad.corner_d_y;
    assign pt[3][2] = quad.corner_d_z;

    // Edge k runs from corner k to corner k+1; a difference of two 24-bit values
    // always fits in 25 bits, and so does its negation.
    vec_t side [4];
    logic degen_in;

    always_comb
    begin
        degen_in = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                side[k][c] = SIDE_W'($signed({pt[(k + 1) % 4][c][COORD_W-1], pt[(k + 1) % 4][c]})
                                   - $signed({pt[k][c][COORD_W-1], pt[k][c]}));
            end
            if (side[k] == '0)
            begin
                degen_in = 1'b1;
            end
        end
    end

    vec_t u_reg [NUM_LANES];
    vec_t v_reg [NUM_LANES];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                u_reg[k] <= side[k];
                for (int c = 0; c < 3; c++)
                begin
                    v_reg[k][c] <= SIDE_W'(-$signed(side[(k + 3) % 4][c]));
                end
            end
        end
    end

    // Valid and degenerate flags travel beside the lanes, one bit per stage.
    logic valid_pipe_reg [LANE_DEPTH+1];
    logic degen_pipe_reg [LANE_DEPTH+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LANE_DEPTH; s++)
            begin
                valid_pipe_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_pipe_reg[0] <= quad.valid;
            for (int s = 1; s <= LANE_DEPTH; s++)
            begin
                valid_pipe_reg[s] <= valid_pipe_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            degen_pipe_reg[0] <= degen_in;
            for (int s = 1; s <= LANE_DEPTH; s++)
            begin
                degen_pipe_reg[s] <= degen_pipe_reg[s-1];
            end
        end
    end

    sine_t lane_sine [NUM_LANES];

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++)
        begin : g_lane
            qmcsj_lane u_lane (
                .clk  (clk),
                .en   (advance),
                .u    (u_reg[g]),
                .v    (v_reg[g]),
                .sine (lane_sine[g])
            );
        end
    endgenerate

    sine_t merged;

    qmcsj_merge u_merge (
        .lane_sine (lane_sine),
        .degen     (degen_pipe_reg[LANE_DEPTH]),
        .merged    (merged)
    );

    // Output register: the result waits here until the sink takes the transfer.
    logic  out_valid_reg;
    sine_t out_sine_reg;
    logic  out_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid_pipe_reg[LANE_DEPTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sine_reg  <= merged;
            out_degen_reg <= degen_pipe_reg[LANE_DEPTH];
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.min_corner_sine = out_sine_reg;
    assign result.degenerate      = out_degen_reg;

`include "assert_macros.svh"

    // A degenerate quad always reports a zero sine.
    `QMCSJ_ASSERT(a_degen_zero, clk, rst_n, result.valid && result.degenerate |-> result.min_corner_sine == '0, "degenerate result with nonzero sine")
    // No sine exceeds one in Q1.15.
    `QMCSJ_ASSERT(a_sine_range, clk, rst_n, result.valid |-> result.min_corner_sine <= SINE_ONE, "sine above one")
    // Every lane root of a quad with no zero edge is within range when it reaches the merge.
    `QMCSJ_ASSERT(a_lane_range, clk, rst_n, valid_pipe_reg[LANE_DEPTH] && !degen_pipe_reg[LANE_DEPTH] |-> lane_sine[0] <= SINE_ONE && lane_sine[1] <= SINE_ONE && lane_sine[2] <= SINE_ONE && lane_sine[3] <= SINE_ONE, "lane sine above one")

endmodule : quad_min_corner_scaled_jacobian

`default_nettype wire
